@@ rtl/abrs_pkg.sv @@
// ----------------------------------------------------------------------------
// abrs_pkg
// Shared types, constants and helpers of the ambiguous-base run screen.
// ----------------------------------------------------------------------------
package abrs_pkg;

  localparam int CountBits = 20;
  localparam int OutBits   = 20;
  localparam int BpBits    = 14;
  localparam int LimBits   = 20;
  localparam int ProdBits  = CountBits + BpBits;
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 20;

  localparam logic [CountBits-1:0] CountMax  = {CountBits{1'b1}};
  localparam logic [BpBits-1:0]    FracScale = BpBits'(10000);
  localparam logic [2:0]           BaseN     = 3'd4;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgFracBp   = 2'd0,
    CfgLongest  = 2'd1,
    CfgEndRun   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CountBits-1:0] n_total;
    logic [CountBits-1:0] longest;
    logic [CountBits-1:0] head;
    logic [CountBits-1:0] tail;
    logic [CountBits-1:0] length;
  } counts_t;

  typedef struct packed {
    logic [BpBits-1:0]  frac_bp;
    logic [LimBits-1:0] longest;
    logic [LimBits-1:0] end_run;
  } limits_t;

  function automatic logic [CountBits-1:0] sat_inc(logic [CountBits-1:0] v);
    return (v == CountMax) ? v : v + CountBits'(1);
  endfunction

  function automatic logic [OutBits-1:0] to_out(logic [CountBits-1:0] v);
    logic [CountBits+OutBits-1:0] w;
    w = {{OutBits{1'b0}}, v};
    return w[OutBits-1:0];
  endfunction

  function automatic logic [ProdBits-1:0] widen(logic [CountBits-1:0] v);
    return {{BpBits{1'b0}}, v};
  endfunction

  // true when a count exceeds a 20-bit limit
  function automatic logic over_lim(logic [CountBits-1:0] v, logic [LimBits-1:0] lim);
    logic [CountBits+LimBits-1:0] a;
    logic [CountBits+LimBits-1:0] b;
    a = {{LimBits{1'b0}}, v};
    b = {{CountBits{1'b0}}, lim};
    return a > b;
  endfunction

endpackage

@@ rtl/ambiguous_base_run_screen.sv @@
// ----------------------------------------------------------------------------
// ambiguous_base_run_screen
// Streams nucleotide codes and screens each region for ambiguous-base runs.
// ----------------------------------------------------------------------------
// One base is taken every cycle while input ready is high. Codes 4 to 7 count
// as N. The transfer marked last closes the region; its result passes through
// three registers: a snapshot register loaded at the transfer, a stage holding
// the two fraction products, and the result register. Non-last bases produce
// nothing. Input ready drops only when the snapshot stage is blocked by a
// stalled result. Counters saturate; the user must write limits through the
// config port only while the block is idle; the block does not enforce it.
module ambiguous_base_run_screen (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [abrs_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [abrs_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [2:0]                     base_i,
  input  logic                           last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [abrs_pkg::OutBits-1:0]   n_total_o,
  output logic [abrs_pkg::OutBits-1:0]   longest_run_o,
  output logic [abrs_pkg::OutBits-1:0]   head_run_o,
  output logic [abrs_pkg::OutBits-1:0]   tail_run_o,
  output logic [abrs_pkg::OutBits-1:0]   region_length_o,
  output logic                           valid_res_o
);

  abrs_pkg::limits_t lim_q, lim_d;
  abrs_pkg::counts_t snap;
  logic              snap_valid;
  logic              take;

  always_comb begin
    lim_d = lim_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        abrs_pkg::CfgFracBp:  lim_d.frac_bp = cfg_data_i[abrs_pkg::BpBits-1:0];
        abrs_pkg::CfgLongest: lim_d.longest = cfg_data_i[abrs_pkg::LimBits-1:0];
        abrs_pkg::CfgEndRun:  lim_d.end_run = cfg_data_i[abrs_pkg::LimBits-1:0];
        default:              lim_d = lim_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q.frac_bp <= abrs_pkg::BpBits'(100);
      lim_q.longest <= abrs_pkg::LimBits'(5);
      lim_q.end_run <= abrs_pkg::LimBits'(20);
    end else begin
      lim_q <= lim_d;
    end
  end

  assign take = in_valid_i && in_ready_o;

  abrs_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .base_i       (base_i),
    .last_i       (last_i),
    .snap_valid_o (snap_valid),
    .snap_o       (snap)
  );

  abrs_check u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .snap_valid_i    (snap_valid),
    .snap_i          (snap),
    .lim_i           (lim_q),
    .take_ready_o    (in_ready_o),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .n_total_o       (n_total_o),
    .longest_run_o   (longest_run_o),
    .head_run_o      (head_run_o),
    .tail_run_o      (tail_run_o),
    .region_length_o (region_length_o),
    .valid_res_o     (valid_res_o)
  );

endmodule

@@ rtl/abrs_accum.sv @@
// ----------------------------------------------------------------------------
// abrs_accum
// Per-region counters: updated on every input transfer, snapshot on last.
// ----------------------------------------------------------------------------
module abrs_accum (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  logic [2:0]            base_i,
  input  logic                  last_i,
  output logic                  snap_valid_o,
  output abrs_pkg::counts_t     snap_o
);

  logic [abrs_pkg::CountBits-1:0] run_q, run_d;
  logic [abrs_pkg::CountBits-1:0] n_q, n_d;
  logic [abrs_pkg::CountBits-1:0] longest_q, longest_d;
  logic [abrs_pkg::CountBits-1:0] head_q, head_d;
  logic [abrs_pkg::CountBits-1:0] len_q, len_d;
  logic                           seen_q, seen_d;
  logic                           is_n;

  always_comb begin
    is_n      = base_i >= abrs_pkg::BaseN;
    len_d     = abrs_pkg::sat_inc(len_q);
    run_d     = run_q;
    n_d       = n_q;
    longest_d = longest_q;
    head_d    = head_q;
    seen_d    = seen_q;
    if (is_n) begin
      run_d = abrs_pkg::sat_inc(run_q);
      n_d   = abrs_pkg::sat_inc(n_q);
      if (run_d > longest_q) begin
        longest_d = run_d;
      end
    end else begin
      if (!seen_q) begin
        head_d = run_q;
        seen_d = 1'b1;
      end
      run_d = '0;
    end
  end

  assign snap_valid_o   = take_i && last_i;
  assign snap_o.n_total = n_d;
  assign snap_o.longest = longest_d;
  assign snap_o.head    = seen_d ? head_d : '0;
  assign snap_o.tail    = run_d;
  assign snap_o.length  = len_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= '0;
      n_q       <= '0;
      longest_q <= '0;
      head_q    <= '0;
      len_q     <= '0;
      seen_q    <= 1'b0;
    end else if (take_i) begin
      if (last_i) begin
        run_q     <= '0;
        n_q       <= '0;
        longest_q <= '0;
        head_q    <= '0;
        len_q     <= '0;
        seen_q    <= 1'b0;
      end else begin
        run_q     <= run_d;
        n_q       <= n_d;
        longest_q <= longest_d;
        head_q    <= head_d;
        len_q     <= len_d;
        seen_q    <= seen_d;
      end
    end
  end

endmodule

@@ rtl/abrs_check.sv @@
// ----------------------------------------------------------------------------
// abrs_check
// Limit checks on a region snapshot and the result register.
// ----------------------------------------------------------------------------
module abrs_check (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        snap_valid_i,
  input  abrs_pkg::counts_t           snap_i,
  input  abrs_pkg::limits_t           lim_i,
  output logic                        take_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [abrs_pkg::OutBits-1:0] n_total_o,
  output logic [abrs_pkg::OutBits-1:0] longest_run_o,
  output logic [abrs_pkg::OutBits-1:0] head_run_o,
  output logic [abrs_pkg::OutBits-1:0] tail_run_o,
  output logic [abrs_pkg::OutBits-1:0] region_length_o,
  output logic                        valid_res_o
);

  logic                            s1_v_q, s1_v_d;
  abrs_pkg::counts_t               s1_q;
  logic                            s2_v_q, s2_v_d;
  abrs_pkg::counts_t               s2_q;
  logic [abrs_pkg::ProdBits-1:0]   prod_n_q, prod_lim_q;
  logic                            runs_ok_q;
  logic                            out_v_q, out_v_d;
  logic                            adv_out, s2_free, s1_move, s2_move;

  assign adv_out      = !out_v_q || out_ready_i;
  assign s2_move      = s2_v_q && adv_out;
  assign s2_free      = !s2_v_q || adv_out;
  assign s1_move      = s1_v_q && s2_free;
  assign take_ready_o = !s1_v_q || s2_free;

  always_comb begin
    s1_v_d  = snap_valid_i ? 1'b1 : (s1_move ? 1'b0 : s1_v_q);
    s2_v_d  = s1_move ? 1'b1 : (s2_move ? 1'b0 : s2_v_q);
    out_v_d = s2_move ? 1'b1 : (out_ready_i ? 1'b0 : out_v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      s2_v_q  <= s2_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_valid_i) begin
      s1_q <= snap_i;
    end
    if (s1_move) begin
      s2_q       <= s1_q;
      prod_n_q   <= abrs_pkg::widen(s1_q.n_total) *
                    {{abrs_pkg::CountBits{1'b0}}, abrs_pkg::FracScale};
      prod_lim_q <= abrs_pkg::widen(s1_q.length) *
                    {{abrs_pkg::CountBits{1'b0}}, lim_i.frac_bp};
      runs_ok_q  <= !abrs_pkg::over_lim(s1_q.longest, lim_i.longest) &&
                    !abrs_pkg::over_lim(s1_q.head, lim_i.end_run) &&
                    !abrs_pkg::over_lim(s1_q.tail, lim_i.end_run);
    end
    if (s2_move) begin
      n_total_o       <= abrs_pkg::to_out(s2_q.n_total);
      longest_run_o   <= abrs_pkg::to_out(s2_q.longest);
      head_run_o      <= abrs_pkg::to_out(s2_q.head);
      tail_run_o      <= abrs_pkg::to_out(s2_q.tail);
      region_length_o <= abrs_pkg::to_out(s2_q.length);
      valid_res_o     <= runs_ok_q && !(prod_n_q > prod_lim_q);
    end
  end

  assign out_valid_o = out_v_q;

endmodule
